[rtl/eit_pkg.sv]
`timescale 1ns / 1ps
package eit_pkg;

   localparam int unsigned MS_WIDTH      = 22;
   localparam int unsigned TICK_WIDTH    = 11;
   localparam int unsigned TOTAL_WIDTH   = 32;
   localparam int unsigned COUNT_WIDTH   = 8;
   localparam int unsigned STEP_WIDTH    = 6;

   // microseconds per millisecond
   localparam logic [9:0]  US_PER_MS     = 10'd1000;
   // quotient bits produced by the divider, one per cycle
   localparam logic [STEP_WIDTH-1:0] DIV_STEPS = 6'd32;
   // ctc divisor search runs from the top down, a divisor of one needs no trial
   localparam logic [COUNT_WIDTH-1:0] DIVISOR_FIRST = 8'd255;
   localparam logic [COUNT_WIDTH-1:0] DIVISOR_LAST  = 8'd2;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX     = 8'd255;

   // item kinds carried on req_tuser
   localparam logic MODE_SET_TIME = 1'b0;
   localparam logic MODE_TICK     = 1'b1;

   // timer_mode register codes
   localparam logic TIMER_NORMAL = 1'b0;
   localparam logic TIMER_CTC    = 1'b1;

   // register indexes
   localparam logic CSR_TIMER_MODE   = 1'b0;
   localparam logic CSR_TICK_TIME_US = 1'b1;

   localparam logic [TICK_WIDTH-1:0] TICK_TIME_RESET = 11'd128;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_TOTAL,
      ST_TRY,
      ST_WAIT
   } state_type;

   typedef struct packed {
      logic                   timer_mode;
      logic [TICK_WIDTH-1:0]  tick_time_us;
   } cfg_type;

   typedef struct packed {
      logic                   start;
      logic [TOTAL_WIDTH-1:0] dividend;
      logic [TICK_WIDTH-1:0]  divisor;
   } div_cmd_type;

   typedef struct packed {
      logic                   done;
      logic [TOTAL_WIDTH-1:0] quotient;
      logic [TICK_WIDTH-1:0]  remainder;
   } div_rsp_type;

   // counter preload that makes the first overflow absorb the remainder
   function automatic logic [COUNT_WIDTH-1:0] preload_of(input logic [COUNT_WIDTH-1:0] rem);
      return 8'(9'h100 - {1'b0, rem});
   endfunction

endpackage

[rtl/eit_div.sv]
`timescale 1ns / 1ps
module eit_div (
   input  logic                  clock,
   input  logic                  reset,
   input  eit_pkg::div_cmd_type  cmd,
   output eit_pkg::div_rsp_type  rsp
);

   logic [eit_pkg::STEP_WIDTH-1:0]  cnt_ff,  cnt_in;
   logic [eit_pkg::TOTAL_WIDTH-1:0] quo_ff,  quo_in;
   logic [eit_pkg::TICK_WIDTH-1:0]  rem_ff,  rem_in;
   logic [eit_pkg::TICK_WIDTH-1:0]  dvs_ff,  dvs_in;
   logic                            done_ff, done_in;

   logic [eit_pkg::TICK_WIDTH:0]    trial;
   logic [eit_pkg::TICK_WIDTH:0]    diff;
   logic                            fits;

   // restoring division, one quotient bit a cycle
   always_comb begin
      trial = {rem_ff, quo_ff[eit_pkg::TOTAL_WIDTH-1]};
      diff  = trial - {1'b0, dvs_ff};
      fits  = (trial >= {1'b0, dvs_ff});
   end

   always_comb begin
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         cnt_in = eit_pkg::DIV_STEPS;
         quo_in = cmd.dividend;
         rem_in = '0;
         dvs_in = cmd.divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         quo_in  = {quo_ff[eit_pkg::TOTAL_WIDTH-2:0], fits};
         rem_in  = fits ? diff[eit_pkg::TICK_WIDTH-1:0] : trial[eit_pkg::TICK_WIDTH-1:0];
         done_in = (cnt_ff == eit_pkg::STEP_WIDTH'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign rsp.done      = done_ff;
   assign rsp.quotient  = quo_ff;
   assign rsp.remainder = rem_ff;

endmodule

[rtl/eit_ctrl.sv]
`timescale 1ns / 1ps
module eit_ctrl (
   input  logic                                clock,
   input  logic                                reset,
   input  eit_pkg::cfg_type                    cfg,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_mode,
   input  logic [eit_pkg::MS_WIDTH-1:0]        req_time_ms,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_fired,
   output logic [eit_pkg::TOTAL_WIDTH-1:0]     rsp_target_count,
   output logic [eit_pkg::COUNT_WIDTH-1:0]     rsp_reload_value,
   output logic [eit_pkg::COUNT_WIDTH-1:0]     rsp_counter_value,
   output eit_pkg::div_cmd_type                div_cmd,
   input  eit_pkg::div_rsp_type                div_rsp
);

   eit_pkg::state_type state_ff, state_in;

   logic [eit_pkg::COUNT_WIDTH-1:0] tick_count_ff, tick_count_in;
   logic [eit_pkg::COUNT_WIDTH-1:0] compare_ff,    compare_in;
   logic [eit_pkg::COUNT_WIDTH-1:0] remainder_ff,  remainder_in;
   logic [eit_pkg::TOTAL_WIDTH-1:0] needed_ff,     needed_in;
   logic [eit_pkg::TOTAL_WIDTH-1:0] seen_ff,       seen_in;
   logic [eit_pkg::TOTAL_WIDTH-1:0] prod_ff,       prod_in;
   logic [eit_pkg::TOTAL_WIDTH-1:0] total_ff,      total_in;
   logic [eit_pkg::COUNT_WIDTH-1:0] divisor_ff,    divisor_in;

   logic                            rsp_valid_ff,   rsp_valid_in;
   logic                            rsp_fired_ff,   rsp_fired_in;
   logic [eit_pkg::TOTAL_WIDTH-1:0] rsp_target_ff,  rsp_target_in;
   logic [eit_pkg::COUNT_WIDTH-1:0] rsp_reload_ff,  rsp_reload_in;
   logic [eit_pkg::COUNT_WIDTH-1:0] rsp_counter_ff, rsp_counter_in;

   logic                            accept;
   logic [eit_pkg::TICK_WIDTH-1:0]  tick_div;
   logic                            adv_event;
   logic                            adv_fired;
   logic [eit_pkg::COUNT_WIDTH-1:0] adv_tick;
   logic [eit_pkg::TOTAL_WIDTH-1:0] adv_seen;
   logic [eit_pkg::TOTAL_WIDTH-1:0] seen_inc;
   logic [eit_pkg::COUNT_WIDTH-1:0] total_rem;

   assign req_ready = (state_ff == eit_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign tick_div  = (cfg.tick_time_us == '0) ? eit_pkg::TICK_WIDTH'(1) : cfg.tick_time_us;
   assign total_rem = div_rsp.quotient[eit_pkg::COUNT_WIDTH-1:0];

   // one timer tick against the current state
   always_comb begin
      seen_inc  = seen_ff + 1'b1;
      adv_event = 1'b0;
      adv_fired = 1'b0;
      adv_tick  = tick_count_ff + 1'b1;
      adv_seen  = seen_ff;
      if (cfg.timer_mode == eit_pkg::TIMER_NORMAL) begin
         adv_event = (tick_count_ff == eit_pkg::COUNT_MAX);
      end else if (tick_count_ff == compare_ff) begin
         adv_event = 1'b1;
         adv_tick  = '0;
      end
      if (adv_event) begin
         adv_seen = seen_inc;
         if (needed_ff != '0 && seen_inc == needed_ff) begin
            adv_fired = 1'b1;
            adv_seen  = '0;
            if (cfg.timer_mode == eit_pkg::TIMER_NORMAL) begin
               adv_tick = eit_pkg::preload_of(remainder_ff);
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         eit_pkg::ST_IDLE: begin
            if (accept && req_mode == eit_pkg::MODE_SET_TIME) begin
               state_in = eit_pkg::ST_MUL;
            end
         end
         eit_pkg::ST_MUL: begin
            state_in = eit_pkg::ST_TOTAL;
         end
         eit_pkg::ST_TOTAL: begin
            if (div_rsp.done) begin
               state_in = (cfg.timer_mode == eit_pkg::TIMER_NORMAL) ?
                          eit_pkg::ST_IDLE : eit_pkg::ST_TRY;
            end
         end
         eit_pkg::ST_TRY: begin
            state_in = eit_pkg::ST_WAIT;
         end
         eit_pkg::ST_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder == '0 || divisor_ff == eit_pkg::DIVISOR_LAST) begin
                  state_in = eit_pkg::ST_IDLE;
               end else begin
                  state_in = eit_pkg::ST_TRY;
               end
            end
         end
         default: state_in = eit_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      tick_count_in  = tick_count_ff;
      compare_in     = compare_ff;
      remainder_in   = remainder_ff;
      needed_in      = needed_ff;
      seen_in        = seen_ff;
      prod_in        = prod_ff;
      total_in       = total_ff;
      divisor_in     = divisor_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_fired_in   = rsp_fired_ff;
      rsp_target_in  = rsp_target_ff;
      rsp_reload_in  = rsp_reload_ff;
      rsp_counter_in = rsp_counter_ff;
      div_cmd.start    = 1'b0;
      div_cmd.dividend = prod_ff;
      div_cmd.divisor  = tick_div;
      unique case (state_ff)
         eit_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_mode == eit_pkg::MODE_TICK) begin
                  tick_count_in  = adv_tick;
                  seen_in        = adv_seen;
                  rsp_valid_in   = 1'b1;
                  rsp_fired_in   = adv_fired;
                  rsp_target_in  = needed_ff;
                  rsp_reload_in  = (cfg.timer_mode == eit_pkg::TIMER_NORMAL) ?
                                   eit_pkg::preload_of(remainder_ff) : compare_ff;
                  rsp_counter_in = adv_tick;
               end else begin
                  prod_in = eit_pkg::TOTAL_WIDTH'(req_time_ms) *
                            eit_pkg::TOTAL_WIDTH'(eit_pkg::US_PER_MS);
               end
            end
         end
         eit_pkg::ST_MUL: begin
            div_cmd.start = 1'b1;
         end
         eit_pkg::ST_TOTAL: begin
            if (div_rsp.done) begin
               total_in   = div_rsp.quotient;
               divisor_in = eit_pkg::DIVISOR_FIRST;
               if (cfg.timer_mode == eit_pkg::TIMER_NORMAL) begin
                  remainder_in = total_rem;
                  needed_in    = eit_pkg::TOTAL_WIDTH'(div_rsp.quotient[eit_pkg::TOTAL_WIDTH-1:
                                 eit_pkg::COUNT_WIDTH]) + eit_pkg::TOTAL_WIDTH'(total_rem != '0);
                  seen_in      = '0;
                  if (total_rem != '0) begin
                     tick_count_in = eit_pkg::preload_of(total_rem);
                  end
                  rsp_valid_in   = 1'b1;
                  rsp_fired_in   = 1'b0;
                  rsp_target_in  = needed_in;
                  rsp_reload_in  = eit_pkg::preload_of(total_rem);
                  rsp_counter_in = tick_count_in;
               end
            end
         end
         eit_pkg::ST_TRY: begin
            div_cmd.start    = 1'b1;
            div_cmd.dividend = total_ff;
            div_cmd.divisor  = eit_pkg::TICK_WIDTH'(divisor_ff);
         end
         eit_pkg::ST_WAIT: begin
            if (div_rsp.done) begin
               if (div_rsp.remainder == '0 || divisor_ff == eit_pkg::DIVISOR_LAST) begin
                  // even divisor found, or none above one left: period of that divisor, or of one tick
                  if (div_rsp.remainder == '0) begin
                     compare_in = divisor_ff - 1'b1;
                     needed_in  = div_rsp.quotient;
                  end else begin
                     compare_in = '0;
                     needed_in  = total_ff;
                  end
                  seen_in        = '0;
                  rsp_valid_in   = 1'b1;
                  rsp_fired_in   = 1'b0;
                  rsp_target_in  = needed_in;
                  rsp_reload_in  = compare_in;
                  rsp_counter_in = tick_count_ff;
               end else begin
                  divisor_in = divisor_ff - 1'b1;
               end
            end
         end
         default: begin
            div_cmd.start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= eit_pkg::ST_IDLE;
         tick_count_ff <= '0;
         compare_ff    <= '0;
         remainder_ff  <= '0;
         needed_ff     <= '0;
         seen_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         tick_count_ff <= tick_count_in;
         compare_ff    <= compare_in;
         remainder_ff  <= remainder_in;
         needed_ff     <= needed_in;
         seen_ff       <= seen_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      prod_ff        <= prod_in;
      total_ff       <= total_in;
      divisor_ff     <= divisor_in;
      rsp_fired_ff   <= rsp_fired_in;
      rsp_target_ff  <= rsp_target_in;
      rsp_reload_ff  <= rsp_reload_in;
      rsp_counter_ff <= rsp_counter_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fired         = rsp_fired_ff;
   assign rsp_target_count  = rsp_target_ff;
   assign rsp_reload_value  = rsp_reload_ff;
   assign rsp_counter_value = rsp_counter_ff;

endmodule

[rtl/extended_interval_timer.sv]
`timescale 1ns / 1ps
// 8-bit interval timer stretched by a 32-bit event counter.
// req channel: req_tuser selects the item kind (0 set time and rearm, 1 one
// prescaled timer tick); req_tdata carries the interval in milliseconds.
// rsp channel: one item back for every request item, carrying the fired
// flag, the event target, the preload or compare value and the counter.
// csr port: csr_index 0 is timer_mode (0 overflow counting, 1 compare match),
// index 1 is tick_time_us; writes land at the clock edge with csr_we high.
// A tick item's result is registered and valid in the cycle after it is taken.
// A set-time item runs through a shared one-bit-per-cycle divider: first for
// the tick total, and in compare mode again for each divisor tried from 255
// down, at most 254 tries, until one divides the total evenly.
// Only one item is in flight; req_tready is low while it is worked on.
// The result sits in an output register; a new item is taken in the cycle
// the previous result leaves, and a stalled rsp_tready holds off req_tready.
// Reset (synchronous) clears the counters and target and restores
// tick_time_us to 128 and overflow mode.
module extended_interval_timer (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic         req_tuser,   // mode
   input  logic [23:0]  req_tdata,   // desired_time_ms[21:0], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [55:0]  rsp_tdata,   // fired, target_count[31:0], reload_value[7:0],
                                     // counter_value[7:0], zero pad
   input  logic         csr_we,
   input  logic         csr_index,
   input  logic [10:0]  csr_wdata
);

   logic                                    timer_mode_ff, timer_mode_in;
   logic [eit_pkg::TICK_WIDTH-1:0]          tick_time_ff,  tick_time_in;
   eit_pkg::cfg_type                        cfg;
   eit_pkg::div_cmd_type                    div_cmd;
   eit_pkg::div_rsp_type                    div_rsp;
   logic                                    fired;
   logic [eit_pkg::TOTAL_WIDTH-1:0]         target_count;
   logic [eit_pkg::COUNT_WIDTH-1:0]         reload_value;
   logic [eit_pkg::COUNT_WIDTH-1:0]         counter_value;

   always_comb begin
      timer_mode_in = timer_mode_ff;
      tick_time_in  = tick_time_ff;
      if (csr_we) begin
         unique case (csr_index)
            eit_pkg::CSR_TIMER_MODE:   timer_mode_in = csr_wdata[0];
            eit_pkg::CSR_TICK_TIME_US: tick_time_in  = csr_wdata;
            default:                   tick_time_in  = tick_time_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_mode_ff <= eit_pkg::TIMER_NORMAL;
         tick_time_ff  <= eit_pkg::TICK_TIME_RESET;
      end else begin
         timer_mode_ff <= timer_mode_in;
         tick_time_ff  <= tick_time_in;
      end
   end

   assign cfg.timer_mode   = timer_mode_ff;
   assign cfg.tick_time_us = tick_time_ff;

   eit_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_tvalid),
      .req_ready         (req_tready),
      .req_mode          (req_tuser),
      .req_time_ms       (req_tdata[eit_pkg::MS_WIDTH-1:0]),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_fired         (fired),
      .rsp_target_count  (target_count),
      .rsp_reload_value  (reload_value),
      .rsp_counter_value (counter_value),
      .div_cmd           (div_cmd),
      .div_rsp           (div_rsp)
   );

   eit_div u_div (
      .clock (clock),
      .reset (reset),
      .cmd   (div_cmd),
      .rsp   (div_rsp)
   );

   assign rsp_tdata = {7'b0, counter_value, reload_value, target_count, fired};

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;

   localparam int unsigned WATCHDOG_LIMIT = 40000;
   localparam int unsigned DRAIN_CYCLES   = 20;
   localparam int unsigned PHASE_ITEMS    = 110;
   localparam int unsigned MAX_REPORTS    = 20;
   localparam logic [7:0]  TOP_DIVISOR    = 8'd255;
   localparam logic [21:0] MS_MAX         = 22'h3FFFFF;

   typedef struct packed {
      logic        fired;
      logic [31:0] target;
      logic [7:0]  reload;
      logic [7:0]  counter;
   } timer_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = eit_pkg::MODE_TICK;
   logic [23:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_index = eit_pkg::CSR_TIMER_MODE;
   logic [10:0] csr_wdata = '0;

   // timer state as the block should hold it
   logic        exp_mode = eit_pkg::TIMER_NORMAL;
   logic [10:0] exp_tick_us = eit_pkg::TICK_TIME_RESET;
   logic [7:0]  exp_count = '0;
   logic [7:0]  exp_compare = '0;
   logic [7:0]  exp_remainder = '0;
   logic [31:0] exp_needed = '0;
   logic [31:0] exp_seen = '0;

   timer_result_type pending_results[$];
   timer_result_type got_result;

   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int mismatch_count = 0;
   int items_sent = 0;
   int results_checked = 0;
   int fire_count = 0;
   int normal_set_count = 0;
   int ctc_set_count = 0;
   int unsigned quiet_cycles = 0;

   always #2 clock = ~clock;

   extended_interval_timer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   function automatic timer_result_type predict_timer_step(input logic kind,
                                                           input logic [21:0] ms);
      timer_result_type res;
      logic [31:0]      total;
      logic [63:0]      divisor;
      logic [7:0]       d;
      logic             hit;
      res.fired = 1'b0;
      if (kind == eit_pkg::MODE_SET_TIME) begin
         divisor = (exp_tick_us == 0) ? 64'd1 : 64'(exp_tick_us);
         total = 32'((64'(ms) * 64'd1000) / divisor);
         if (exp_mode == eit_pkg::TIMER_NORMAL) begin
            normal_set_count++;
            exp_remainder = total[7:0];
            exp_needed = (total >> 8) + ((total[7:0] != 0) ? 32'd1 : 32'd0);
            if (total[7:0] != 0)
               exp_count = 8'd0 - total[7:0];
         end else begin
            ctc_set_count++;
            d = TOP_DIVISOR;
            while (d > 1 && (total % d) != 0)
               d--;
            exp_needed = total / d;
            exp_compare = d - 8'd1;
         end
         exp_seen = '0;
      end else begin
         if (exp_mode == eit_pkg::TIMER_NORMAL) begin
            hit = (exp_count == 8'hFF);
            exp_count = exp_count + 8'd1;
         end else if (exp_count == exp_compare) begin
            hit = 1'b1;
            exp_count = '0;
         end else begin
            hit = 1'b0;
            exp_count = exp_count + 8'd1;
         end
         if (hit) begin
            exp_seen = exp_seen + 32'd1;
            if (exp_needed != 0 && exp_seen == exp_needed) begin
               exp_seen = '0;
               res.fired = 1'b1;
               if (exp_mode == eit_pkg::TIMER_NORMAL)
                  exp_count = 8'd0 - exp_remainder;
            end
         end
      end
      res.target = exp_needed;
      res.reload = (exp_mode == eit_pkg::TIMER_NORMAL) ? 8'd0 - exp_remainder : exp_compare;
      res.counter = exp_count;
      return res;
   endfunction

   function automatic logic [21:0] random_ms();
      int unsigned pick;
      int unsigned tick_us;
      pick = $urandom_range(99);
      tick_us = (exp_tick_us == 0) ? 32'd1 : 32'(exp_tick_us);
      // mostly totals of a few hundred ticks so that intervals do elapse
      if (pick < 60)
         return 22'(($urandom_range(600) * tick_us) / 1000);
      else if (pick < 85)
         return 22'($urandom_range(4000));
      return 22'($urandom_range(MS_MAX));
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("mismatch at %0t ns: %s", $time, what);
   endtask

   task automatic send_item(input logic kind, input logic [21:0] ms);
      @(negedge clock);
      if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(negedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {2'b00, ms};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(predict_timer_step(kind, ms));
      items_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic index, input logic [10:0] value);
      drain_results();
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      if (index == eit_pkg::CSR_TIMER_MODE)
         exp_mode = value[0];
      else
         exp_tick_us = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_idling(input int sender_pct, input int receiver_pct);
      sender_idle_pct = sender_pct;
      receiver_stall_pct = receiver_pct;
   endtask

   // counter and target as they come out of reset, default tick time
   task automatic test_reset_state();
      send_item(eit_pkg::MODE_TICK, '0);
      send_item(eit_pkg::MODE_TICK, MS_MAX);
      send_item(eit_pkg::MODE_SET_TIME, '0);
      send_item(eit_pkg::MODE_TICK, '0);
   endtask

   // one-tick interval fires every tick, zero remainder leaves the counter alone
   task automatic test_normal_mode();
      write_csr(eit_pkg::CSR_TIMER_MODE, 11'(eit_pkg::TIMER_NORMAL));
      write_csr(eit_pkg::CSR_TICK_TIME_US, 11'd1000);
      send_item(eit_pkg::MODE_SET_TIME, 22'd1);
      send_item(eit_pkg::MODE_TICK, '0);
      send_item(eit_pkg::MODE_TICK, '0);
      send_item(eit_pkg::MODE_SET_TIME, MS_MAX);
      send_item(eit_pkg::MODE_SET_TIME, 22'd256);
      send_item(eit_pkg::MODE_TICK, '0);
   endtask

   // zero total, largest total, prime total (longest divisor search), small period
   task automatic test_ctc_mode();
      write_csr(eit_pkg::CSR_TIMER_MODE, 11'(eit_pkg::TIMER_CTC));
      write_csr(eit_pkg::CSR_TICK_TIME_US, 11'd1);
      send_item(eit_pkg::MODE_SET_TIME, '0);
      send_item(eit_pkg::MODE_TICK, '0);
      send_item(eit_pkg::MODE_SET_TIME, MS_MAX);
      write_csr(eit_pkg::CSR_TICK_TIME_US, 11'd1000);
      send_item(eit_pkg::MODE_SET_TIME, 22'd257);
      send_item(eit_pkg::MODE_TICK, '0);
      send_item(eit_pkg::MODE_SET_TIME, 22'd3);
      repeat (4) send_item(eit_pkg::MODE_TICK, '0);
   endtask

   // a tick time of zero divides as one
   task automatic test_zero_tick_time();
      write_csr(eit_pkg::CSR_TIMER_MODE, 11'(eit_pkg::TIMER_NORMAL));
      write_csr(eit_pkg::CSR_TICK_TIME_US, 11'd0);
      send_item(eit_pkg::MODE_SET_TIME, 22'd1);
      send_item(eit_pkg::MODE_TICK, '0);
   endtask

   // mode change with no new set time: ticks follow the current mode
   task automatic test_mode_switch();
      write_csr(eit_pkg::CSR_TIMER_MODE, 11'(eit_pkg::TIMER_CTC));
      send_item(eit_pkg::MODE_TICK, '0);
      send_item(eit_pkg::MODE_TICK, '0);
   endtask

   task automatic test_random_phase(input int phase);
      int          sent;
      int          run_len;
      logic [10:0] tick_us;
      case (phase)
         0, 7:    tick_us = 11'd128;
         1, 4:    tick_us = 11'd1024;
         2, 3:    tick_us = 11'd1;
         default: tick_us = 11'($urandom_range(1, 1024));
      endcase
      write_csr(eit_pkg::CSR_TIMER_MODE,
                11'((phase % 2 == 0) ? eit_pkg::TIMER_NORMAL : eit_pkg::TIMER_CTC));
      write_csr(eit_pkg::CSR_TICK_TIME_US, tick_us);
      case (phase % 4)
         0: set_idling(0, 0);
         1: set_idling(57, 0);
         2: set_idling(0, 57);
         default: set_idling(9, 9);
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
         if ($urandom_range(9) == 0) begin
            // lone item of either kind
            send_item(logic'($urandom_range(1)), random_ms());
            sent++;
         end else begin
            run_len = ($urandom_range(9) < 7) ? $urandom_range(1, 40)
                                              : $urandom_range(41, 300);
            // keep the phase near its item budget
            if (run_len > int'(PHASE_ITEMS) - sent - 1)
               run_len = int'(PHASE_ITEMS) - sent - 1;
            send_item(eit_pkg::MODE_SET_TIME, random_ms());
            repeat (run_len) send_item(eit_pkg::MODE_TICK, 22'($urandom));
            sent += run_len + 1;
         end
      end
      drain_results();
   endtask

   always @(negedge clock)
      rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with nothing expected, data %h", rsp_tdata));
         end else begin
            got_result = pending_results.pop_front();
            results_checked++;
            if (got_result.fired)
               fire_count++;
            if (rsp_tdata[0] !== got_result.fired)
               report_mismatch($sformatf("fired %b, expected %b",
                                         rsp_tdata[0], got_result.fired));
            if (rsp_tdata[32:1] !== got_result.target)
               report_mismatch($sformatf("target_count %0d, expected %0d",
                                         rsp_tdata[32:1], got_result.target));
            if (rsp_tdata[40:33] !== got_result.reload)
               report_mismatch($sformatf("reload_value %0d, expected %0d",
                                         rsp_tdata[40:33], got_result.reload));
            if (rsp_tdata[48:41] !== got_result.counter)
               report_mismatch($sformatf("counter_value %0d, expected %0d",
                                         rsp_tdata[48:41], got_result.counter));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no item moved for %0d cycles, %0d results outstanding",
                  quiet_cycles, pending_results.size());
         $display("tb_top: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      set_idling(0, 0);
      test_reset_state();
      test_normal_mode();
      test_ctc_mode();
      test_zero_tick_time();
      test_mode_switch();
      for (int phase = 0; phase < 8; phase++)
         test_random_phase(phase);
      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d items, %0d results checked, %0d intervals elapsed",
               items_sent, results_checked, fire_count);
      $display("set time items: %0d overflow mode, %0d compare mode, %0d mismatches",
               normal_set_count, ctc_set_count, mismatch_count);
      if (mismatch_count == 0 && pending_results.size() == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

endmodule

[files.f]
rtl/eit_pkg.sv
rtl/eit_div.sv
rtl/eit_ctrl.sv
rtl/extended_interval_timer.sv
verif/tb_top.sv
